// ----- sv/cnm_pkg.sv -----
package cnm_pkg;

  localparam int ACC_W      = 64;
  localparam int LIMB_W     = 32;
  localparam int HALF_SCALE = 32768;
  localparam int SCORE_W    = 16;
  localparam int ID_W       = 9;
  localparam int CFG_W      = 9;
  localparam int ENTRY_W    = 8;
  localparam int ELEM_W     = 7;
  localparam int VALUE_W    = 16;

  localparam logic OP_GALLERY = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QRD,
    ST_QMUL,
    ST_QACC,
    ST_QSAVE,
    ST_ENTRY,
    ST_GRD,
    ST_GMUL1,
    ST_GMUL2,
    ST_GACC,
    ST_SCORE,
    ST_SWAIT,
    ST_DONE
  } cnm_state_t;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_MUL,
    MAC_MUL_DOT,
    MAC_SQ
  } mac_op_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_PROD,
    SC_DSQ,
    SC_KSQ,
    SC_KMUL,
    SC_OUT
  } sc_state_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] score;
  } sc_result_t;

endpackage

// ----- sv/cnm_mac.sv -----
module cnm_mac
  import cnm_pkg::*;
#(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  mac_op_t                        op,
  input  logic signed [ELEMENT_BITS-1:0] a,
  input  logic signed [ELEMENT_BITS-1:0] b,
  output logic        [ACC_W-1:0]        dot,
  output logic        [ACC_W-1:0]        sq
);

  logic signed [2*ELEMENT_BITS-1:0] prod;
  logic        [ACC_W-1:0]          prod_ext;

  // sign extend the product, sums wrap at the accumulator width
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    case (op)
      MAC_CLEAR: begin
        dot <= '0;
        sq  <= '0;
      end
      MAC_MUL: begin
        prod <= a * b;
      end
      MAC_MUL_DOT: begin
        dot  <= dot + prod_ext;
        prod <= a * b;
      end
      MAC_SQ: begin
        sq <= sq + prod_ext;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cnm_lmul.sv -----
module cnm_lmul
  import cnm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [4*LIMB_W-1:0] a,
  input  logic [2*LIMB_W-1:0] b,
  output logic                done,
  output logic [6*LIMB_W-1:0] prod
);

  logic                run;
  logic [2:0]          cnt;
  logic [2*LIMB_W-1:0] pp;
  logic [2:0]          pp_sh;
  logic                pp_vld;
  logic [LIMB_W-1:0]   a_limb;
  logic [LIMB_W-1:0]   b_limb;
  logic [7:0]          sh_amt;

  // cnt[1:0] walks the limbs of a, cnt[2] the limbs of b
  assign a_limb = a[int'(cnt[1:0]) * LIMB_W +: LIMB_W];
  assign b_limb = b[int'(cnt[2]) * LIMB_W +: LIMB_W];
  assign sh_amt = 8'(int'(pp_sh) * LIMB_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      cnt    <= '0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= pp_vld && !run;
      pp_vld <= run;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= '0;
    end else if (pp_vld) begin
      prod <= prod + ((6*LIMB_W)'(pp) << sh_amt);
    end
    if (run) begin
      pp    <= a_limb * b_limb;
      pp_sh <= {1'b0, cnt[1:0]} + {2'b00, cnt[2]};
    end
  end

endmodule

// ----- sv/cnm_score.sv -----
module cnm_score
  import cnm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] dot,
  input  logic [ACC_W-1:0] mq,
  input  logic [ACC_W-1:0] mg,
  output sc_result_t       result
);

  localparam logic [15:0] HALF = 16'(HALF_SCALE);

  sc_state_t state, state_next;

  logic                neg;
  logic [ACC_W-1:0]    mag;
  logic [ACC_W-1:0]    mq_r;
  logic [ACC_W-1:0]    mg_r;
  logic [2*ACC_W-1:0]  p;
  logic [2*ACC_W-1:0]  d2;
  logic [15:0]         lo;
  logic [15:0]         hi;
  logic [15:0]         mid;
  logic [LIMB_W-1:0]   kk;
  logic                fin;
  logic                eqf;
  logic                pend;

  logic                lm_start;
  logic                lm_done;
  logic [4*LIMB_W-1:0] lm_a;
  logic [2*LIMB_W-1:0] lm_b;
  logic [6*LIMB_W-1:0] lm_prod;
  logic [6*LIMB_W-1:0] rhs;
  logic                le;
  logic                eq;
  logic [15:0]         lo_n;
  logic [15:0]         hi_n;
  logic [16:0]         sum_n;
  logic [16:0]         sum_c;
  logic [15:0]         mid_n;
  logic [15:0]         mid_c;
  logic [16:0]         pos_s;
  logic [16:0]         ceil_c;
  logic [16:0]         neg_s;

  cnm_lmul u_lmul (
    .clk   (clk),
    .rst   (rst),
    .start (lm_start),
    .a     (lm_a),
    .b     (lm_b),
    .done  (lm_done),
    .prod  (lm_prod)
  );

  // k^2 * |q|^2 |g|^2 against 2^30 * dot^2
  assign rhs   = (6*LIMB_W)'(d2) << 30;
  assign le    = lm_prod <= rhs;
  assign eq    = lm_prod == rhs;
  assign lo_n  = le ? mid : lo;
  assign hi_n  = le ? hi : mid - 16'd1;
  assign sum_n = 17'(lo_n) + 17'(hi_n) + 17'd1;
  assign mid_n = sum_n[16:1];
  assign sum_c = 17'(lo) + 17'(hi) + 17'd1;
  assign mid_c = sum_c[16:1];

  assign pos_s  = 17'(HALF) + 17'(lo);
  assign ceil_c = (!eqf && lo < HALF) ? 17'(lo) + 17'd1 : 17'(lo);
  assign neg_s  = 17'(HALF) - ceil_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (lm_start) begin
        pend <= 1'b1;
      end else if (lm_done) begin
        pend <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: if (start) state_next = SC_PROD;
      SC_PROD: if (lm_done) state_next = SC_DSQ;
      SC_DSQ:  if (lm_done) state_next = SC_KSQ;
      SC_KSQ:  if (lm_done) state_next = SC_KMUL;
      SC_KMUL: begin
        if (lm_done) begin
          if (fin) begin
            state_next = SC_OUT;
          end else if (lo_n < hi_n || neg) begin
            state_next = SC_KSQ;
          end else begin
            state_next = SC_OUT;
          end
        end
      end
      SC_OUT:  state_next = SC_IDLE;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    lm_a         = '0;
    lm_b         = '0;
    lm_start     = 1'b0;
    result.done  = 1'b0;
    result.score = '0;
    unique case (state)
      SC_PROD: begin
        lm_a = (4*LIMB_W)'(mq_r);
        lm_b = mg_r;
      end
      SC_DSQ: begin
        lm_a = (4*LIMB_W)'(mag);
        lm_b = mag;
      end
      SC_KSQ: begin
        lm_a = (4*LIMB_W)'(mid);
        lm_b = (2*LIMB_W)'(mid);
      end
      SC_KMUL: begin
        lm_a = p;
        lm_b = (2*LIMB_W)'(kk);
      end
      SC_OUT: begin
        result.done = 1'b1;
        if (neg) begin
          result.score = neg_s[15:0];
        end else begin
          result.score = pos_s[16] ? {SCORE_W{1'b1}} : pos_s[15:0];
        end
      end
      default: ;
    endcase
    if (state != SC_IDLE && state != SC_OUT && !pend) begin
      lm_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          neg  <= dot[ACC_W-1];
          mag  <= dot[ACC_W-1] ? ~dot + 1'b1 : dot;
          mq_r <= mq;
          mg_r <= mg;
          lo   <= '0;
          hi   <= HALF;
          fin  <= 1'b0;
          eqf  <= 1'b0;
        end
      end
      SC_PROD: if (lm_done) p <= lm_prod[2*ACC_W-1:0];
      SC_DSQ: begin
        if (lm_done) begin
          d2  <= lm_prod[2*ACC_W-1:0];
          mid <= mid_c;
        end
      end
      SC_KSQ: if (lm_done) kk <= lm_prod[LIMB_W-1:0];
      SC_KMUL: begin
        if (lm_done) begin
          if (fin) begin
            eqf <= eq;
          end else begin
            lo <= lo_n;
            hi <= hi_n;
            if (lo_n < hi_n) begin
              mid <= mid_n;
            end else begin
              // search settled, one more compare at the floor for rounding up
              fin <= 1'b1;
              mid <= lo_n;
            end
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/cosine_nearest_match_unit.sv -----
// cosine nearest match: keeps a gallery of feature vectors and returns the
// entry most like a query by cosine similarity, scored as (cos+1)/2 in Q0.16.
// input channel (in_valid/in_ready): one element write per transfer;
// operation 0 writes gallery element, operation 1 writes a query element,
// and a query element with last set starts a search. in_ready is high only
// while the block is idle.
// output channel (out_valid/out_ready): one result per search, matched_id
// (1-based, 0 when nothing scored) and similarity. the result sits in an
// output register, so new writes are taken while it waits; a later search
// holds at its end until the previous result is taken.
// entries_in_use is written through cfg_write_en/cfg_write_data.
// a search first forms the query norm, then for each entry runs the shared
// multiply-accumulate and the score unit, whose 32x32 limb multiplier runs
// a 15 or 16 step binary search for the scaled square root; one search at
// a time.
// reset clears control state and entries_in_use; the vector stores are not
// cleared and must be written before they are read.
module cosine_nearest_match_unit
  import cnm_pkg::*;
#(
  parameter int GALLERY_DEPTH = 256,
  parameter int FEATURE_LEN   = 128,
  parameter int ELEMENT_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [CFG_W-1:0]          cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      operation,
  input  logic [ENTRY_W-1:0]        entry_index,
  input  logic [ELEM_W-1:0]         element_index,
  input  logic signed [VALUE_W-1:0] element_value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ID_W-1:0]           matched_id,
  output logic [SCORE_W-1:0]        similarity
);

  localparam int IW    = $clog2(FEATURE_LEN);
  localparam int IXW   = (IW > ELEM_W) ? IW : ELEM_W;
  localparam int GAW   = $clog2(GALLERY_DEPTH * FEATURE_LEN);
  localparam int EW0   = $clog2(GALLERY_DEPTH + 1);
  localparam int EW    = (EW0 > CFG_W) ? EW0 : CFG_W;
  localparam int GSIZE = GALLERY_DEPTH * FEATURE_LEN;

  cnm_state_t state, state_next;

  logic signed [ELEMENT_BITS-1:0] gmem [GSIZE];
  logic signed [ELEMENT_BITS-1:0] qmem [FEATURE_LEN];
  logic signed [ELEMENT_BITS-1:0] qdata;
  logic signed [ELEMENT_BITS-1:0] gdata;

  logic [CFG_W-1:0]   entries_in_use;
  logic [IW-1:0]      elem;
  logic [GAW-1:0]     gaddr;
  logic [EW-1:0]      entry;
  logic [ACC_W-1:0]   mq;
  logic [SCORE_W-1:0] best;
  logic [ID_W-1:0]    best_id;

  logic               accept;
  logic               elem_last;
  logic [EW-1:0]      n_eff;
  logic [EW-1:0]      eiu_ext;
  logic [EW-1:0]      entry_inc;
  logic [31:0]        val_ext;
  logic signed [ELEMENT_BITS-1:0] val_ld;
  logic [IXW-1:0]     elem_wide;
  logic [IW-1:0]      q_waddr;
  logic [GAW-1:0]     g_waddr;
  logic               elem_ok;
  logic               entry_ok;

  mac_op_t                        mac_op;
  logic signed [ELEMENT_BITS-1:0] mac_a;
  logic signed [ELEMENT_BITS-1:0] mac_b;
  logic [ACC_W-1:0]               dot;
  logic [ACC_W-1:0]               sq;
  logic                           sc_start;
  sc_result_t                     sc_res;

  cnm_mac #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .dot (dot),
    .sq  (sq)
  );

  cnm_score u_score (
    .clk    (clk),
    .rst    (rst),
    .start  (sc_start),
    .dot    (dot),
    .mq     (mq),
    .mg     (sq),
    .result (sc_res)
  );

  assign accept    = in_valid && in_ready;
  assign elem_last = elem == IW'(FEATURE_LEN - 1);
  assign eiu_ext   = EW'(entries_in_use);
  assign n_eff     = (eiu_ext > EW'(GALLERY_DEPTH)) ? EW'(GALLERY_DEPTH) : eiu_ext;
  assign entry_inc = entry + EW'(1);

  // sign extend to 32 bits, keep the low element bits
  assign val_ext   = {{(32-VALUE_W){element_value[VALUE_W-1]}}, element_value};
  assign val_ld    = val_ext[ELEMENT_BITS-1:0];
  assign elem_wide = IXW'(element_index);
  assign q_waddr   = elem_wide[IW-1:0];
  assign g_waddr   = GAW'(32'(entry_index) * FEATURE_LEN + 32'(element_index));
  assign elem_ok   = 32'(element_index) < FEATURE_LEN;
  assign entry_ok  = 32'(entry_index) < GALLERY_DEPTH;

  always_ff @(posedge clk) begin
    if (accept && elem_ok) begin
      if (operation == OP_QUERY) begin
        qmem[q_waddr] <= val_ld;
      end else if (entry_ok) begin
        gmem[g_waddr] <= val_ld;
      end
    end
    qdata <= qmem[elem];
    gdata <= gmem[gaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entries_in_use <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        entries_in_use <= cfg_write_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end else if (state == ST_DONE) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && operation == OP_QUERY && last) state_next = ST_QRD;
      ST_QRD:   state_next = ST_QMUL;
      ST_QMUL:  state_next = ST_QACC;
      ST_QACC:  state_next = elem_last ? ST_QSAVE : ST_QRD;
      ST_QSAVE: state_next = ST_ENTRY;
      ST_ENTRY: state_next = (entry == n_eff) ? ST_DONE : ST_GRD;
      ST_GRD:   state_next = ST_GMUL1;
      ST_GMUL1: state_next = ST_GMUL2;
      ST_GMUL2: state_next = ST_GACC;
      ST_GACC:  state_next = elem_last ? ST_SCORE : ST_GRD;
      ST_SCORE: state_next = (mq == '0 || sq == '0) ? ST_ENTRY : ST_SWAIT;
      ST_SWAIT: if (sc_res.done) state_next = ST_ENTRY;
      ST_DONE:  if (!out_valid) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mac_op   = MAC_HOLD;
    mac_a    = qdata;
    mac_b    = gdata;
    sc_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mac_op   = MAC_CLEAR;
      end
      ST_QMUL: begin
        mac_op = MAC_MUL;
        mac_b  = qdata;
      end
      ST_QACC:  mac_op = MAC_SQ;
      ST_QSAVE: mac_op = MAC_CLEAR;
      ST_ENTRY: mac_op = MAC_CLEAR;
      ST_GMUL1: mac_op = MAC_MUL;
      ST_GMUL2: begin
        mac_op = MAC_MUL_DOT;
        mac_a  = gdata;
      end
      ST_GACC:  mac_op = MAC_SQ;
      ST_SCORE: sc_start = !(mq == '0 || sq == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        elem    <= '0;
        entry   <= '0;
        best    <= '0;
        best_id <= '0;
      end
      ST_QACC: elem <= elem_last ? '0 : elem + IW'(1);
      ST_QSAVE: begin
        mq    <= sq;
        gaddr <= '0;
      end
      ST_GACC: begin
        elem  <= elem_last ? '0 : elem + IW'(1);
        gaddr <= gaddr + GAW'(1);
      end
      ST_SCORE: begin
        if (mq == '0 || sq == '0) begin
          entry <= entry_inc;
        end
      end
      ST_SWAIT: begin
        if (sc_res.done) begin
          entry <= entry_inc;
          // strictly greater only, so the first entry keeps a tie
          if (sc_res.score > best) begin
            best    <= sc_res.score;
            best_id <= entry_inc[ID_W-1:0];
          end
        end
      end
      ST_DONE: begin
        if (!out_valid) begin
          matched_id <= best_id;
          similarity <= best;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_id_no_score: assert property (@(posedge clk) disable iff (rst)
    (out_valid && matched_id == '0) |-> similarity == '0)
    else $error("result with no match carries a score");

  a_score_in_wait: assert property (@(posedge clk) disable iff (rst)
    sc_res.done |-> state == ST_SWAIT)
    else $error("score unit finished outside its wait state");

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ENTRY |-> entry <= n_eff)
    else $error("entry walk ran past the entries in use");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the end of a search");
`endif

endmodule
